// ===== design/cvg_pkg.sv =====
// ----------------------------------------------------------------------------
// Cylinder vertex generator package
// Shared widths, section and register codes, count clamping and the
// quarter-wave sine table that is built at elaboration.
// ----------------------------------------------------------------------------
package cvg_pkg;

    // Mesh limits and angle format.
    localparam int MAX_SLICES = 256;
    localparam int MAX_STACKS = 256;
    localparam int ANGLE_BITS = 12;
    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
    localparam int ROM_AW     = ANGLE_BITS - 1;

    // Field widths.
    localparam int IDX_W  = 17;
    localparam int LEN_W  = 16;
    localparam int CNT_W  = 9;
    localparam int SEC_W  = 3;
    localparam int XY_W   = 17;
    localparam int SIN_W  = 15;
    localparam int TOT_W  = 18;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CYL_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 3'd4;

    // Section codes.
    localparam logic [SEC_W-1:0] SECT_TOP_CENTRE    = 3'd0;
    localparam logic [SEC_W-1:0] SECT_TOP_RIM       = 3'd1;
    localparam logic [SEC_W-1:0] SECT_BOTTOM_CENTRE = 3'd2;
    localparam logic [SEC_W-1:0] SECT_BOTTOM_RIM    = 3'd3;
    localparam logic [SEC_W-1:0] SECT_SIDE          = 3'd4;

    // Ring choice: caps use ring zero or the last ring, the side divides.
    typedef enum logic [1:0] {
        RING_TOP  = 2'd0,
        RING_BASE = 2'd1,
        RING_SIDE = 2'd2
    } ring_sel_t;

    // Pipelined divider geometry.
    localparam int DIV_NUM_W    = 28;
    localparam int DIV_DEN_W    = 10;
    localparam int DIV_PER_STG  = 4;
    localparam int DIV_LAT      = DIV_NUM_W / DIV_PER_STG;

    // Sine table in Q1.14, entries 0 to QUARTER.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    typedef logic [SIN_W-1:0] sine_rom_t [0:QUARTER];

    // Exact unsigned quotient by shift and subtract, evaluated at elaboration.
    function automatic longint unsigned const_udiv(input longint unsigned a,
                                                   input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], a[b]};
            q = {q[62:0], 1'b0};
            if (r >= d)
            begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       tab;
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint          e;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x    = (HALF_PI_Q30 * longint'(k)) >> (ANGLE_BITS - 2);
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = const_udiv(term, longint'((2 * n) * (2 * n + 1)));
                if ((n % 2) == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            e = (acc + 32768) / 65536;
            if (e > 16384)
                e = 16384;
            tab[k] = SIN_W'(e);
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // A count of zero acts as one, a count above the limit as the limit.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input int hi);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (int'(v) > hi)
            r = CNT_W'(hi);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== design/cvg_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, four quotient bits per stage, one word per cycle while en is high.
// ----------------------------------------------------------------------------
module cvg_divider
    import cvg_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_NUM_W-1:0] quo,
    output logic [DIV_DEN_W-1:0] rem
);

    // Per stage: numerator bits shift out at the top, quotient bits in below.
    logic [DIV_NUM_W-1:0] nq_reg  [0:DIV_LAT-1];
    logic [DIV_DEN_W-1:0] rem_reg [0:DIV_LAT-1];
    logic [DIV_DEN_W-1:0] den_reg [0:DIV_LAT-1];
    logic [DIV_NUM_W-1:0] nq_next  [0:DIV_LAT-1];
    logic [DIV_DEN_W-1:0] rem_next [0:DIV_LAT-1];
    logic [DIV_NUM_W-1:0] nq_src   [0:DIV_LAT-1];
    logic [DIV_DEN_W-1:0] rem_src  [0:DIV_LAT-1];
    logic [DIV_DEN_W-1:0] den_src  [0:DIV_LAT-1];

    genvar st;
    generate
        for (st = 0; st < DIV_LAT; st++)
        begin : g_stage
            // The first stage starts from the new word with a zero remainder.
            if (st == 0)
            begin : g_first
                assign nq_src[st]  = num;
                assign rem_src[st] = '0;
                assign den_src[st] = den;
            end
            else
            begin : g_rest
                assign nq_src[st]  = nq_reg[st-1];
                assign rem_src[st] = rem_reg[st-1];
                assign den_src[st] = den_reg[st-1];
            end

            // DIV_PER_STG compare and subtract steps on the narrow remainder.
            always_comb
            begin : step
                logic [DIV_DEN_W:0]   r_t;
                logic [DIV_NUM_W-1:0] q_t;
                r_t = {1'b0, rem_src[st]};
                q_t = nq_src[st];
                for (int i = 0; i < DIV_PER_STG; i++)
                begin
                    r_t = {r_t[DIV_DEN_W-1:0], q_t[DIV_NUM_W-1]};
                    q_t = {q_t[DIV_NUM_W-2:0], 1'b0};
                    if (r_t >= {1'b0, den_src[st]})
                    begin
                        r_t    = r_t - {1'b0, den_src[st]};
                        q_t[0] = 1'b1;
                    end
                end
                nq_next[st]  = q_t;
                rem_next[st] = r_t[DIV_DEN_W-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg[st]  <= nq_next[st];
                    rem_reg[st] <= rem_next[st];
                    den_reg[st] <= den_src[st];
                end
            end
        end
    endgenerate

    assign quo = nq_reg[DIV_LAT-1];
    assign rem = rem_reg[DIV_LAT-1];

endmodule

// ===== design/cylinder_vertex_generator_core.sv =====
// ----------------------------------------------------------------------------
// Cylinder vertex generator core
// Throughput: one index word per cycle; two rounds of pipelined dividers set the depth.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module cylinder_vertex_generator_core
    import cvg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration writes.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // Index words in.
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [IDX_W-1:0]             vertex_index,
    // Vertex words out.
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [XY_W-1:0]       pos_x,
    output logic signed [XY_W-1:0]       pos_y,
    output logic signed [LEN_W-1:0]      pos_z,
    output logic [SEC_W-1:0]             section,
    output logic                         index_error
);

    typedef struct packed {
        logic [SEC_W-1:0] sect;
        logic             err;
        logic             neg;
        ring_sel_t        rsel;
        logic [CNT_W-1:0] icap;
    } side1_t;

    typedef struct packed {
        logic [SEC_W-1:0] sect;
        logic             err;
        logic             neg;
        logic             z_neg;
    } side2_t;

    // Configuration registers.
    logic [LEN_W-1:0] top_radius_reg, base_radius_reg, cyl_height_reg;
    logic [CNT_W-1:0] slice_count_reg, stack_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_radius_reg  <= LEN_W'(256);
            base_radius_reg <= LEN_W'(256);
            cyl_height_reg  <= LEN_W'(256);
            slice_count_reg <= CNT_W'(16);
            stack_count_reg <= CNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TOP_RADIUS:  top_radius_reg  <= cfg_data;
                REG_BASE_RADIUS: base_radius_reg <= cfg_data;
                REG_CYL_HEIGHT:  cyl_height_reg  <= cfg_data;
                REG_SLICE_COUNT: slice_count_reg <= cfg_data[CNT_W-1:0];
                REG_STACK_COUNT: stack_count_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped counts. Change configuration only while the pipeline is empty; unchecked.
    logic [CNT_W-1:0] s_eff, t_eff;
    assign s_eff = clamp_count(slice_count_reg, MAX_SLICES);
    assign t_eff = clamp_count(stack_count_reg, MAX_STACKS);

    // The pipeline advances unless a finished word is held at the output.
    logic en;
    logic out_valid_reg;
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Stage 1: range check and section decode.
    logic [TOT_W-1:0] idx_w, s_w, total, lim_top_rim, lim_bot_c, lim_bot_rim;
    logic [TOT_W-1:0] k_w;
    side1_t           s1_next;

    always_comb
    begin
        idx_w       = TOT_W'(vertex_index);
        s_w         = TOT_W'(s_eff);
        total       = ((s_w + TOT_W'(2)) << 1)
                    + (TOT_W'(t_eff) + TOT_W'(1)) * (s_w + TOT_W'(1));
        lim_top_rim = s_w + TOT_W'(1);
        lim_bot_c   = s_w + TOT_W'(2);
        lim_bot_rim = (s_w << 1) + TOT_W'(3);
        k_w         = idx_w - (s_w << 1) - TOT_W'(4);

        s1_next.err  = (idx_w >= total);
        s1_next.neg  = 1'b0;
        s1_next.icap = '0;
        if (idx_w == '0)
        begin
            s1_next.sect = SECT_TOP_CENTRE;
            s1_next.rsel = RING_TOP;
        end
        else if (idx_w <= lim_top_rim)
        begin
            s1_next.sect = SECT_TOP_RIM;
            s1_next.rsel = RING_TOP;
            s1_next.icap = CNT_W'(idx_w - TOT_W'(1));
        end
        else if (idx_w == lim_bot_c)
        begin
            s1_next.sect = SECT_BOTTOM_CENTRE;
            s1_next.rsel = RING_BASE;
        end
        else if (idx_w <= lim_bot_rim)
        begin
            s1_next.sect = SECT_BOTTOM_RIM;
            s1_next.rsel = RING_BASE;
            s1_next.neg  = 1'b1;
            s1_next.icap = CNT_W'(idx_w - s_w - TOT_W'(3));
        end
        else
        begin
            s1_next.sect = SECT_SIDE;
            s1_next.rsel = RING_SIDE;
        end
    end

    logic             s1_valid_reg;
    side1_t           s1_reg;
    logic [IDX_W-1:0] s1_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            s1_k_reg <= k_w[IDX_W-1:0];
        end
    end

    // Divider 1: side offset into ring number and point within the ring.
    logic [DIV_NUM_W-1:0] d1_quo;
    logic [DIV_DEN_W-1:0] d1_rem;

    cvg_divider u_div_ring (
        .clk (clk),
        .en  (en),
        .num (DIV_NUM_W'(s1_k_reg)),
        .den (DIV_DEN_W'(s_eff) + DIV_DEN_W'(1)),
        .quo (d1_quo),
        .rem (d1_rem)
    );

    logic   d1_valid_reg [0:DIV_LAT-1];
    side1_t d1_side_reg  [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                d1_valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            d1_valid_reg[0] <= s1_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
                d1_valid_reg[i] <= d1_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_side_reg[0] <= s1_reg;
            for (int i = 1; i < DIV_LAT; i++)
                d1_side_reg[i] <= d1_side_reg[i-1];
        end
    end

    // Stage 2: pick ring and point index.
    side1_t           d1_out;
    logic [CNT_W-1:0] ring_next, pidx_next;

    assign d1_out = d1_side_reg[DIV_LAT-1];

    always_comb
    begin
        case (d1_out.rsel)
            RING_TOP:
            begin
                ring_next = '0;
                pidx_next = d1_out.icap;
            end
            RING_BASE:
            begin
                ring_next = t_eff;
                pidx_next = d1_out.icap;
            end
            default:
            begin
                ring_next = d1_quo[CNT_W-1:0];
                pidx_next = d1_rem[CNT_W-1:0];
            end
        endcase
    end

    logic             s2_valid_reg;
    side1_t           s2_side_reg;
    logic [CNT_W-1:0] s2_ring_reg, s2_pidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= d1_valid_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= d1_out;
            s2_ring_reg <= ring_next;
            s2_pidx_reg <= pidx_next;
        end
    end

    // Stage 3: numerators for radius, height and phase.
    localparam int NUMW = 25;
    logic [NUMW-1:0]  rad_num_next, z_num_next;
    logic [10:0]      z_diff;
    logic [CNT_W-1:0] z_mag;
    logic             z_neg_next;

    always_comb
    begin
        rad_num_next = NUMW'(top_radius_reg) * NUMW'(t_eff - s2_ring_reg)
                     + NUMW'(base_radius_reg) * NUMW'(s2_ring_reg);
        z_diff       = {2'b00, t_eff} - {1'b0, s2_ring_reg, 1'b0};
        z_neg_next   = z_diff[10];
        z_mag        = z_neg_next ? CNT_W'(11'd0 - z_diff) : z_diff[CNT_W-1:0];
        z_num_next   = NUMW'(cyl_height_reg) * NUMW'(z_mag);
    end

    logic                 s3_valid_reg;
    side2_t               s3_side_reg;
    logic [NUMW-1:0]      s3_rad_num_reg, s3_z_num_reg;
    logic [CNT_W-1:0]     s3_pidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg.sect  <= s2_side_reg.sect;
            s3_side_reg.err   <= s2_side_reg.err;
            s3_side_reg.neg   <= s2_side_reg.neg;
            s3_side_reg.z_neg <= z_neg_next;
            s3_rad_num_reg    <= rad_num_next;
            s3_z_num_reg      <= z_num_next;
            s3_pidx_reg       <= s2_pidx_reg;
        end
    end

    // Divider round 2: phase, radius and height in parallel.
    logic [DIV_NUM_W-1:0] ph_quo, rad_quo, z_quo;
    logic [DIV_DEN_W-1:0] ph_rem, rad_rem, z_rem;

    cvg_divider u_div_phase (
        .clk (clk),
        .en  (en),
        .num (DIV_NUM_W'({s3_pidx_reg, {ANGLE_BITS{1'b0}}})),
        .den (DIV_DEN_W'(s_eff)),
        .quo (ph_quo),
        .rem (ph_rem)
    );

    cvg_divider u_div_radius (
        .clk (clk),
        .en  (en),
        .num (DIV_NUM_W'(s3_rad_num_reg)),
        .den (DIV_DEN_W'(t_eff)),
        .quo (rad_quo),
        .rem (rad_rem)
    );

    cvg_divider u_div_height (
        .clk (clk),
        .en  (en),
        .num (DIV_NUM_W'(s3_z_num_reg)),
        .den ({t_eff, 1'b0}),
        .quo (z_quo),
        .rem (z_rem)
    );

    logic   d2_valid_reg [0:DIV_LAT-1];
    side2_t d2_side_reg  [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                d2_valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            d2_valid_reg[0] <= s3_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
                d2_valid_reg[i] <= d2_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_side_reg[0] <= s3_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
                d2_side_reg[i] <= d2_side_reg[i-1];
        end
    end

    // Stage 4: final phase and floored height.
    side2_t                  d2_out;
    logic [ANGLE_BITS-1:0]   phase_next;
    logic [LEN_W:0]          z_wide;
    logic [LEN_W-1:0]        z_next;

    assign d2_out = d2_side_reg[DIV_LAT-1];

    always_comb
    begin
        phase_next = d2_out.neg ? (ANGLE_BITS'(0) - ph_quo[ANGLE_BITS-1:0])
                                : ph_quo[ANGLE_BITS-1:0];
        z_wide     = {1'b0, z_quo[LEN_W-1:0]} + {{LEN_W{1'b0}}, (z_rem != '0)};
        z_next     = d2_out.z_neg ? LEN_W'((LEN_W+1)'(0) - z_wide) : z_quo[LEN_W-1:0];
    end

    logic                  s4_valid_reg;
    side2_t                s4_side_reg;
    logic [ANGLE_BITS-1:0] s4_phase_reg;
    logic [LEN_W-1:0]      s4_radius_reg, s4_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= d2_valid_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg   <= d2_out;
            s4_phase_reg  <= phase_next;
            s4_radius_reg <= rad_quo[LEN_W-1:0];
            s4_z_reg      <= z_next;
        end
    end

    // Stage 5: sine table reads for sine and cosine.
    logic [ANGLE_BITS-1:0] cos_phase;
    logic [ROM_AW-1:0]     sin_addr, cos_addr;
    logic [ROM_AW-1:0]     sin_off, cos_off;

    always_comb
    begin
        cos_phase = s4_phase_reg + ANGLE_BITS'(QUARTER);
        sin_off   = {1'b0, s4_phase_reg[ANGLE_BITS-3:0]};
        cos_off   = {1'b0, cos_phase[ANGLE_BITS-3:0]};
        sin_addr  = s4_phase_reg[ANGLE_BITS-2] ? (ROM_AW'(QUARTER) - sin_off) : sin_off;
        cos_addr  = cos_phase[ANGLE_BITS-2] ? (ROM_AW'(QUARTER) - cos_off) : cos_off;
    end

    logic             s5_valid_reg;
    side2_t           s5_side_reg;
    logic [SIN_W-1:0] s5_sin_reg, s5_cos_reg;
    logic             s5_sin_neg_reg, s5_cos_neg_reg;
    logic [LEN_W-1:0] s5_radius_reg, s5_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg    <= s4_side_reg;
            s5_sin_reg     <= SINE_ROM[sin_addr];
            s5_cos_reg     <= SINE_ROM[cos_addr];
            s5_sin_neg_reg <= s4_phase_reg[ANGLE_BITS-1];
            s5_cos_neg_reg <= cos_phase[ANGLE_BITS-1];
            s5_radius_reg  <= s4_radius_reg;
            s5_z_reg       <= s4_z_reg;
        end
    end

    // Stage 6: radius times sine and cosine magnitudes.
    localparam int PROD_W = LEN_W + SIN_W;

    logic              s6_valid_reg;
    side2_t            s6_side_reg;
    logic [PROD_W-1:0] s6_px_reg, s6_py_reg;
    logic              s6_xneg_reg, s6_yneg_reg;
    logic [LEN_W-1:0]  s6_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (en)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_side_reg <= s5_side_reg;
            s6_px_reg   <= s5_radius_reg * s5_cos_reg;
            s6_py_reg   <= s5_radius_reg * s5_sin_reg;
            s6_xneg_reg <= s5_cos_neg_reg;
            s6_yneg_reg <= s5_sin_neg_reg;
            s6_z_reg    <= s5_z_reg;
        end
    end

    // Output stage: floor of the signed product over 2^14, then masking.
    function automatic logic [XY_W-1:0] floor_q14(input logic [PROD_W-1:0] p,
                                                  input logic neg);
        logic [PROD_W:0]  up;
        logic [XY_W-1:0]  fl;
        logic [XY_W-1:0]  cl;
        up = {1'b0, p} + (PROD_W+1)'(16383);
        fl = XY_W'(p >> 14);
        cl = XY_W'(up >> 14);
        return neg ? (XY_W'(0) - cl) : fl;
    endfunction

    logic             rim, keep;
    logic [XY_W-1:0]  x_next, y_next;

    always_comb
    begin
        rim    = (s6_side_reg.sect != SECT_TOP_CENTRE)
              && (s6_side_reg.sect != SECT_BOTTOM_CENTRE);
        keep   = !s6_side_reg.err;
        x_next = (rim && keep) ? floor_q14(s6_px_reg, s6_xneg_reg) : '0;
        y_next = (rim && keep) ? floor_q14(s6_py_reg, s6_yneg_reg) : '0;
    end

    logic [XY_W-1:0]  pos_x_reg, pos_y_reg;
    logic [LEN_W-1:0] pos_z_reg;
    logic [SEC_W-1:0] section_reg;
    logic             index_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg       <= x_next;
            pos_y_reg       <= y_next;
            pos_z_reg       <= keep ? s6_z_reg : '0;
            section_reg     <= keep ? s6_side_reg.sect : SECT_TOP_CENTRE;
            index_error_reg <= s6_side_reg.err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = $signed(pos_x_reg);
    assign pos_y       = $signed(pos_y_reg);
    assign pos_z       = $signed(pos_z_reg);
    assign section     = section_reg;
    assign index_error = index_error_reg;

`ifndef ASSERT_OFF
    // An index past the end delivers an all-zero vertex.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |->
            pos_x == '0 && pos_y == '0 && pos_z == '0 && section == SECT_TOP_CENTRE)
        else $error("out-of-range index produced a nonzero vertex");

    // Cap centres sit on the axis.
    a_centre_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (section == SECT_TOP_CENTRE || section == SECT_BOTTOM_CENTRE)
            |-> pos_x == '0 && pos_y == '0)
        else $error("cap centre vertex off the axis");

    // A held output word is still offered on the next cycle.
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("held output word was lost");
`endif

endmodule

// ===== tb/sv/tb_cylinder_vertex_generator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cylinder vertex generator core testbench
// Drives vertex index words under several mesh settings, predicts every
// vertex word and compares the output stream field by field in order.
// ----------------------------------------------------------------------------
module tb_cylinder_vertex_generator_core;
    import cvg_pkg::*;

    typedef struct packed {
        logic [XY_W-1:0]  x;
        logic [XY_W-1:0]  y;
        logic [LEN_W-1:0] z;
        logic [SEC_W-1:0] sect;
        logic             err;
    } vertex_t;

    // Mesh settings plus the sine table, and the queue of pending vertices.
    class vertex_scoreboard;
        int unsigned top_r = 256;
        int unsigned base_r = 256;
        int unsigned height = 256;
        int unsigned slices = 16;
        int unsigned stacks = 1;
        longint      sin_q14 [0:QUARTER];
        vertex_t     pending [$];

        function new();
            longint unsigned x;
            longint unsigned term;
            longint          acc;
            longint          e;
            for (int k = 0; k <= QUARTER; k++)
            begin
                x = (64'd1686629713 * k) / QUARTER;
                term = x;
                acc = x;
                for (int n = 1; n <= 7; n++)
                begin
                    term = (term * x) >> 30;
                    term = (term * x) >> 30;
                    term = term / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        acc = acc - longint'(term);
                    else
                        acc = acc + longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                e = (acc + 32768) / 65536;
                if (e > 16384)
                    e = 16384;
                sin_q14[k] = e;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TOP_RADIUS:  top_r = data;
                REG_BASE_RADIUS: base_r = data;
                REG_CYL_HEIGHT:  height = data;
                REG_SLICE_COUNT: slices = data[CNT_W-1:0];
                REG_STACK_COUNT: stacks = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint fdiv(longint num, longint den);
            longint q;
            q = num / den;
            if ((num % den != 0) && (num < 0))
                q = q - 1;
            return q;
        endfunction

        function longint sine(int unsigned p);
            int unsigned quad;
            int unsigned off;
            longint      v;
            p = p % (1 << ANGLE_BITS);
            quad = p >> (ANGLE_BITS - 2);
            off = p % QUARTER;
            v = quad[0] ? sin_q14[QUARTER - off] : sin_q14[off];
            return quad[1] ? -v : v;
        endfunction

        function int unsigned eff_slices();
            return slices == 0 ? 1 : (slices > MAX_SLICES ? MAX_SLICES : slices);
        endfunction

        function int unsigned eff_stacks();
            return stacks == 0 ? 1 : (stacks > MAX_STACKS ? MAX_STACKS : stacks);
        endfunction

        function int unsigned vertex_total();
            return 2 * (eff_slices() + 2) + (eff_stacks() + 1) * (eff_slices() + 1);
        endfunction

        // Work out the vertex for one accepted index and queue it.
        function void note_index(int unsigned idx);
            int unsigned s;
            int unsigned t;
            int unsigned k;
            int unsigned ring;
            int unsigned ph;
            longint      h;
            longint      r;
            longint      z;
            longint      px;
            longint      py;
            bit          on_rim;
            vertex_t     v;
            s = eff_slices();
            t = eff_stacks();
            h = height;
            r = 0;
            px = 0;
            py = 0;
            ph = 0;
            on_rim = 1'b1;
            v = '0;
            if (idx >= vertex_total())
            begin
                v.err = 1'b1;
                pending = {pending, v};
                return;
            end
            if (idx == 0)
            begin
                v.sect = SECT_TOP_CENTRE;
                z = fdiv(h, 2);
                on_rim = 1'b0;
            end
            else if (idx <= s + 1)
            begin
                v.sect = SECT_TOP_RIM;
                r = top_r;
                z = fdiv(h, 2);
                ph = ((idx - 1) << ANGLE_BITS) / s;
            end
            else if (idx == s + 2)
            begin
                v.sect = SECT_BOTTOM_CENTRE;
                z = fdiv(-h, 2);
                on_rim = 1'b0;
            end
            else if (idx <= 2 * s + 3)
            begin
                v.sect = SECT_BOTTOM_RIM;
                r = base_r;
                z = fdiv(-h, 2);
                ph = (1 << ANGLE_BITS) - ((((idx - (s + 3)) << ANGLE_BITS) / s)
                     % (1 << ANGLE_BITS));
            end
            else
            begin
                k = idx - (2 * s + 4);
                ring = k / (s + 1);
                v.sect = SECT_SIDE;
                r = (longint'(top_r) * (t - ring) + longint'(base_r) * ring) / t;
                z = fdiv(h * (longint'(t) - 2 * longint'(ring)), 2 * longint'(t));
                ph = ((k % (s + 1)) << ANGLE_BITS) / s;
            end
            if (on_rim)
            begin
                px = fdiv(r * sine(ph + QUARTER), 16384);
                py = fdiv(r * sine(ph), 16384);
            end
            v.x = px[XY_W-1:0];
            v.y = py[XY_W-1:0];
            v.z = z[LEN_W-1:0];
            pending = {pending, v};
        endfunction

        // Compare one output word with the oldest pending vertex.
        function bit check_vertex(vertex_t got, output string msg);
            vertex_t want;
            msg = "";
            if (pending.size() == 0)
            begin
                msg = "vertex word with none pending";
                return 1'b0;
            end
            want = pending.pop_front();
            if (got.x !== want.x)
                msg = {msg, $sformatf(" x %0h/%0h", got.x, want.x)};
            if (got.y !== want.y)
                msg = {msg, $sformatf(" y %0h/%0h", got.y, want.y)};
            if (got.z !== want.z)
                msg = {msg, $sformatf(" z %0h/%0h", got.z, want.z)};
            if (got.sect !== want.sect)
                msg = {msg, $sformatf(" section %0d/%0d", got.sect, want.sect)};
            if (got.err !== want.err)
                msg = {msg, $sformatf(" index_error %0b/%0b", got.err, want.err)};
            return msg == "";
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [IDX_W-1:0]         vertex_index;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [XY_W-1:0]   pos_x;
    logic signed [XY_W-1:0]   pos_y;
    logic signed [LEN_W-1:0]  pos_z;
    logic [SEC_W-1:0]         section;
    logic                     index_error;

    vertex_scoreboard sb;
    int               errors;
    int               stall_mode;
    int               burst_left;

    cylinder_vertex_generator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vertex_index (vertex_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .section      (section),
        .index_error  (index_error)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Accepted index words go to the predictor, vertex words are checked.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_index(vertex_index);
            if (out_valid && !out_stall)
            begin
                if (!sb.check_vertex({pos_x, pos_y, pos_z, section, index_error}, msg))
                    report(msg);
            end
        end
    end

    // The receiver stalls on a pattern that changes at random moments.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Stop sending, then wait until every pending vertex has come out.
    task wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data[CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task set_mesh(input int unsigned tr, input int unsigned br, input int unsigned h,
                  input int unsigned s, input int unsigned t);
        wait_drained();
        write_reg(REG_TOP_RADIUS, tr);
        write_reg(REG_BASE_RADIUS, br);
        write_reg(REG_CYL_HEIGHT, h);
        write_reg(REG_SLICE_COUNT, s);
        write_reg(REG_STACK_COUNT, t);
    endtask

    // Send one index word, with bursts of random length and gaps between them.
    task send_index(input int unsigned idx);
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else
            @(negedge clk);
        in_valid = 1'b1;
        vertex_index = idx[IDX_W-1:0];
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task random_phase(input int n);
        int unsigned tot;
        tot = sb.vertex_total();
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                burst_left = 0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 99) < 85)
                send_index($urandom_range(0, tot - 1));
            else
                send_index($urandom_range(0, (1 << IDX_W) - 1));
        end
    endtask

    initial
    begin
        #2000000;
        $display("tb_cylinder_vertex_generator_core: FAIL");
        $finish;
    end

    initial
    begin
        int unsigned s;
        sb = new();
        errors = 0;
        stall_mode = 0;
        burst_left = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        vertex_index = '0;
        out_stall = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk over the section boundaries at the reset settings.
        s = sb.eff_slices();
        send_index(0);
        send_index(1);
        send_index(2);
        send_index(s);
        send_index(s + 1);
        send_index(s + 2);
        send_index(s + 3);
        send_index(s + 4);
        send_index(2 * s + 3);
        send_index(2 * s + 4);
        send_index(3 * s + 5);
        send_index(sb.vertex_total() - 1);
        send_index(sb.vertex_total());
        send_index((1 << IDX_W) - 1);

        // Largest mesh and the end of the index range.
        set_mesh(65535, 65535, 65535, 256, 256);
        send_index(66563);
        send_index(66564);
        send_index(66565);
        send_index(65536);
        random_phase(220);

        // Unknown register index is ignored.
        wait_drained();
        write_reg(3'd5, 16'hFFFF);
        random_phase(150);

        set_mesh(0, 0, 0, 1, 1);
        send_index(0);
        send_index(5);
        send_index(6);
        random_phase(120);

        // Counts of zero and above the limit are clamped.
        set_mesh(65535, 0, 1, 0, 0);
        random_phase(150);
        set_mesh(1, 65535, 65534, 511, 300);
        random_phase(220);
        set_mesh(0, 65535, 65535, 3, 7);
        random_phase(200);
        set_mesh(37000, 12, 4097, 257, 511);
        random_phase(150);

        for (int p = 0; p < 4; p++)
        begin
            set_mesh($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 511),
                     $urandom_range(0, 511));
            random_phase(155);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb_cylinder_vertex_generator_core: PASS");
        else
            $display("tb_cylinder_vertex_generator_core: FAIL");
        $finish;
    end

endmodule
